FILE: src/bamd_pkg.sv
// ----------------------------------------------------------------------------
// bamd_pkg
// Shared types and constants of the bit-angle-modulation LED driver.
// ----------------------------------------------------------------------------
package bamd_pkg;

    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;
    localparam int CCOUNT_W  = 7;
    localparam int BASE_W    = 10;
    localparam int CHAN_W    = 6;
    localparam int VAL_IN_W  = 8;
    localparam int PLANE_OUT_W = 3;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd1;
    localparam logic [OP_W-1:0] OP_SWAP  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKS    = 2'd1;

    localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RESET = 7'd16;
    localparam logic [BASE_W-1:0]   BASE_TICKS_RESET    = 10'd40;

    typedef struct packed {
        logic display_sel;
        logic display_sel_next;
        logic started;
        logic swapped;
    } timer_status_t;

endpackage

FILE: src/bamd_plane_timer.sv
// ----------------------------------------------------------------------------
// bamd_plane_timer
// Bit plane sequencing: tick counter, plane index, pending swap and the
// display buffer select.
// ----------------------------------------------------------------------------
module bamd_plane_timer #(
    parameter int VALUE_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_en,
    input  logic                         swap_req,
    input  logic [bamd_pkg::BASE_W-1:0]  base_ticks,
    output logic [(VALUE_BITS > 1 ? $clog2(VALUE_BITS) : 1)-1:0] plane_next,
    output bamd_pkg::timer_status_t      status
);
    import bamd_pkg::*;

    localparam int PLANE_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int TICK_W  = BASE_W + VALUE_BITS - 1;
    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(VALUE_BITS - 1);

    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [PLANE_W-1:0] plane_reg;
    logic               pending_reg, pending_next;
    logic               disp_reg, disp_next;
    logic [TICK_W-1:0]  base_ext;
    logic [TICK_W-1:0]  dur;
    logic [TICK_W:0]    tick_inc;
    logic               plane_end;
    logic               wrap;

    always_comb
    begin
        base_ext = (base_ticks == '0) ? TICK_W'(1) : TICK_W'(base_ticks);
        dur      = base_ext << plane_reg;
        tick_inc = {1'b0, tick_reg} + (TICK_W+1)'(1);
        plane_end = tick_en && (tick_inc >= {1'b0, dur});
        wrap      = plane_end && (plane_reg == LAST_PLANE);
    end

    always_comb
    begin
        tick_next    = tick_reg;
        plane_next   = plane_reg;
        pending_next = pending_reg || swap_req;
        disp_next    = disp_reg;
        if (tick_en)
        begin
            tick_next = plane_end ? '0 : tick_inc[TICK_W-1:0];
        end
        if (plane_end)
        begin
            plane_next = wrap ? '0 : plane_reg + PLANE_W'(1);
        end
        if (wrap && pending_reg)
        begin
            disp_next    = ~disp_reg;
            pending_next = 1'b0;
        end
    end

    always_comb
    begin
        status.display_sel      = disp_reg;
        status.display_sel_next = disp_next;
        status.started          = plane_end;
        status.swapped          = wrap && pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            plane_reg   <= '0;
            pending_reg <= 1'b0;
            disp_reg    <= 1'b0;
        end
        else
        begin
            tick_reg    <= tick_next;
            plane_reg   <= plane_next;
            pending_reg <= pending_next;
            disp_reg    <= disp_next;
        end
    end

endmodule

FILE: src/bam_led_double_buffered_driver.sv
// ----------------------------------------------------------------------------
// bam_led_double_buffered_driver
// Double-buffered 8-bit bit-angle-modulation LED driver with lit-channel
// output per beat.
// ----------------------------------------------------------------------------
// Result beat: registered, valid in the cycle after its input beat.
// Throughput: one beat per cycle; the result register stalls input only
// while a result waits with out_ready low.
// Reset: both channel buffers, timer and pending swap cleared; channel_count
// 16, base_ticks 40. No clearing pass.
// ----------------------------------------------------------------------------
module bam_led_double_buffered_driver #(
    parameter int MAX_CHANNELS = 64,
    parameter int VALUE_BITS   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bamd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bamd_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bamd_pkg::OP_W-1:0]         op,
    input  logic [bamd_pkg::CHAN_W-1:0]       channel,
    input  logic [bamd_pkg::VAL_IN_W-1:0]     value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [MAX_CHANNELS-1:0]           lit_channels,
    output logic [bamd_pkg::PLANE_OUT_W-1:0]  plane_bit,
    output logic                              plane_started,
    output logic                              frame_swapped
);
    import bamd_pkg::*;

    localparam int PLANE_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [CCOUNT_W-1:0]   channel_count_reg;
    logic [BASE_W-1:0]     base_ticks_reg;
    logic [VALUE_BITS-1:0] buf_a_reg [MAX_CHANNELS];
    logic [VALUE_BITS-1:0] buf_a_next [MAX_CHANNELS];
    logic [VALUE_BITS-1:0] buf_b_reg [MAX_CHANNELS];
    logic [VALUE_BITS-1:0] buf_b_next [MAX_CHANNELS];
    logic                  out_valid_reg, out_valid_next;
    logic [MAX_CHANNELS-1:0] lit_reg, lit_next;
    logic [PLANE_OUT_W-1:0]  plane_out_reg;
    logic                  started_reg, swapped_reg;
    logic                  fire;
    logic                  do_set, do_fill, do_clear, do_swap, do_tick;
    logic [11:0]           value_wide;
    logic [VALUE_BITS-1:0] val_m;
    logic                  set_ok;
    logic [PLANE_W-1:0]    plane_next;
    logic [PLANE_W+2:0]    plane_wide;
    timer_status_t         tstat;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        do_set   = 1'b0;
        do_fill  = 1'b0;
        do_clear = 1'b0;
        do_swap  = 1'b0;
        do_tick  = 1'b0;
        case (op)
            OP_SET:   do_set   = fire;
            OP_FILL:  do_fill  = fire;
            OP_SWAP:  do_swap  = fire;
            OP_CLEAR: do_clear = fire;
            OP_TICK:  do_tick  = fire;
            default:  ;
        endcase
    end

    bamd_plane_timer #(
        .VALUE_BITS (VALUE_BITS)
    ) u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (do_tick),
        .swap_req   (do_swap || do_clear),
        .base_ticks (base_ticks_reg),
        .plane_next (plane_next),
        .status     (tstat)
    );

    always_comb
    begin
        value_wide = {4'b0, value};
        val_m      = value_wide[VALUE_BITS-1:0];
        set_ok     = ({1'b0, channel} < channel_count_reg)
                     && (CCOUNT_W'(channel) < CCOUNT_W'(MAX_CHANNELS));
    end

    // draw buffer is the one not displayed
    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            logic active;
            logic wr;
            logic [VALUE_BITS-1:0] wdata;
            active = CCOUNT_W'(c) < channel_count_reg;
            wr     = active && ((do_set && set_ok && (channel == CHAN_W'(c)))
                                || do_fill || do_clear);
            wdata  = do_clear ? '0 : val_m;
            buf_a_next[c] = buf_a_reg[c];
            buf_b_next[c] = buf_b_reg[c];
            if (wr && tstat.display_sel)
            begin
                buf_a_next[c] = wdata;
            end
            if (wr && !tstat.display_sel)
            begin
                buf_b_next[c] = wdata;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            logic [VALUE_BITS-1:0] shown;
            shown = tstat.display_sel_next ? buf_b_next[c] : buf_a_next[c];
            lit_next[c] = (CCOUNT_W'(c) < channel_count_reg) && shown[plane_next];
        end
        plane_wide = {3'b0, plane_next};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
            base_ticks_reg    <= BASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CCOUNT_W-1:0];
                CFG_BASE_TICKS:    base_ticks_reg    <= cfg_data[BASE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                buf_a_reg[c] <= '0;
                buf_b_reg[c] <= '0;
            end
        end
        else
        begin
            buf_a_reg <= buf_a_next;
            buf_b_reg <= buf_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            lit_reg       <= lit_next;
            plane_out_reg <= plane_wide[PLANE_OUT_W-1:0];
            started_reg   <= tstat.started;
            swapped_reg   <= tstat.swapped;
        end
    end

    assign out_valid     = out_valid_reg;
    assign lit_channels  = lit_reg;
    assign plane_bit     = plane_out_reg;
    assign plane_started = started_reg;
    assign frame_swapped = swapped_reg;

endmodule
